// ===== rtl/sli_pkg.sv =====
// Shared types and codes for the sorted list block.
// Holds the item structs, operation and status codes, and the cell status struct.
// No dependencies.
`default_nettype none

package sli_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DELETED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_READ_OK   = 3'd5;
    localparam logic [2:0] ST_RANGE     = 3'd6;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value;
        logic [3:0]         position;
    } sli_in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [4:0]         entry_count;
        logic [3:0]         affected_position;
        logic signed [31:0] read_value;
    } sli_out_t;

    typedef struct packed {
        logic insert_en;
        logic delete_en;
    } sli_ctrl_t;

    typedef struct packed {
        logic le;
        logic eq;
        logic ins_at;
        logic hit;
        logic rd_hit;
    } sli_stat_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_list_insert_delete_top.sv =====
// Sorted list top level: the chain of entry cells, count register and
// output register. Depends on sli_pkg and sli_cell.
//
// Usage: items arrive on the s_ channel (operation, value, position) and one
// result item per input item leaves on the m_ channel, both valid/ready.
// An insert places the value after all entries less than or equal to it; a
// delete removes the lowest-position equal entry and closes the gap; a read
// returns the entry at the given position. Every cell compares its entry with
// the value in parallel and shifts in the same cycle, so the result is valid in
// the cycle after acceptance, held in the one output register, and one item can
// be accepted every cycle while the receiver keeps m_ready high.
// When the receiver stalls, the result waits in the output register and s_ready
// drops until it is taken, then the next item is accepted in that same cycle.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; entry contents are not cleared and are never read above the count.
`default_nettype none

module sorted_list_insert_delete_top
    import sli_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire sli_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output sli_out_t      m_data
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic signed [31:0] entry_w [CAPACITY];
    sli_stat_t          stat_w  [CAPACITY];
    logic [CAPACITY-1:0] ins_vec;
    logic [CAPACITY-1:0] hit_vec;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    sli_out_t         m_data_reg;
    sli_out_t         m_data_next;

    logic             accept;
    logic             full;
    logic             found;
    logic [3:0]       ins_pos;
    logic [3:0]       hit_pos;
    logic             read_ok;
    logic signed [31:0] read_data;
    sli_ctrl_t        ctrl;

    localparam sli_stat_t HEAD_STAT = '{le: 1'b1, eq: 1'b0, ins_at: 1'b0,
                                        hit: 1'b0, rd_hit: 1'b0};

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = count_reg == CNT_W'(CAPACITY);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic signed [31:0] left_entry;
            sli_stat_t          left_stat;
            logic signed [31:0] right_entry;

            if (g == 0) begin : g_head
                assign left_entry = s_data.value;
                assign left_stat  = HEAD_STAT;
            end else begin : g_mid
                assign left_entry = entry_w[g-1];
                assign left_stat  = stat_w[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign right_entry = entry_w[g];
            end else begin : g_body
                assign right_entry = entry_w[g+1];
            end

            sli_cell #(
                .INDEX (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .value       (s_data.value),
                .position    (s_data.position),
                .count       (count_reg),
                .left_entry  (left_entry),
                .left_stat   (left_stat),
                .right_entry (right_entry),
                .entry       (entry_w[g]),
                .stat        (stat_w[g])
            );

            assign ins_vec[g] = stat_w[g].ins_at;
            assign hit_vec[g] = stat_w[g].hit;
        end
    endgenerate

    always_comb begin
        ins_pos   = '0;
        hit_pos   = '0;
        read_ok   = 1'b0;
        read_data = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            ins_pos   = ins_pos | (stat_w[i].ins_at ? 4'(i) : 4'd0);
            hit_pos   = hit_pos | (stat_w[i].hit ? 4'(i) : 4'd0);
            read_ok   = read_ok | stat_w[i].rd_hit;
            read_data = read_data | (stat_w[i].rd_hit ? entry_w[i] : 32'sd0);
        end
        found = |hit_vec;
    end

    always_comb begin
        ctrl.insert_en = 1'b0;
        ctrl.delete_en = 1'b0;
        count_next     = count_reg;
        m_data_next.status            = ST_RANGE;
        m_data_next.affected_position = '0;
        m_data_next.read_value        = '0;
        unique case (s_data.operation)
            OP_INSERT: begin
                if (full) begin
                    m_data_next.status = ST_FULL;
                end else begin
                    ctrl.insert_en                = accept;
                    count_next                    = count_reg + CNT_W'(1);
                    m_data_next.status            = ST_INSERTED;
                    m_data_next.affected_position = ins_pos;
                end
            end
            OP_DELETE: begin
                if (count_reg == '0) begin
                    m_data_next.status = ST_EMPTY;
                end else if (!found) begin
                    m_data_next.status = ST_NOT_FOUND;
                end else begin
                    ctrl.delete_en                = accept;
                    count_next                    = count_reg - CNT_W'(1);
                    m_data_next.status            = ST_DELETED;
                    m_data_next.affected_position = hit_pos;
                end
            end
            default: begin
                m_data_next.affected_position = s_data.position;
                if (read_ok) begin
                    m_data_next.status     = ST_READ_OK;
                    m_data_next.read_value = read_data;
                end
            end
        endcase
        m_data_next.entry_count = 5'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(ins_vec) && $onehot0(hit_vec))
        else $error("more than one insert or delete position selected");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != CNT_W'(CAPACITY)) |-> $onehot(ins_vec))
        else $error("no unique insert position below capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.entry_count == 5'(count_reg)))
        else $error("reported count differs from stored count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.operation == OP_DELETE && found && count_reg != '0)
        |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("delete did not reduce the count");

endmodule

`default_nettype wire

// ===== rtl/sli_cell.sv =====
// One storage cell of the sorted list chain: holds one entry and compares it
// with the broadcast value, shifting from its left or right neighbor.
// Depends on sli_pkg.
`default_nettype none

module sli_cell
    import sli_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  wire logic               aclk,
    input  wire sli_ctrl_t          ctrl,
    input  wire logic signed [31:0] value,
    input  wire logic [3:0]         position,
    input  wire logic [CNT_W-1:0]   count,
    input  wire logic signed [31:0] left_entry,
    input  wire sli_stat_t          left_stat,
    input  wire logic signed [31:0] right_entry,
    output logic signed [31:0]      entry,
    output sli_stat_t               stat
);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic               below;
    logic               ge;

    always_comb begin
        below       = count > CNT_W'(INDEX);
        stat.le     = below && (entry_reg <= value);
        stat.eq     = below && (entry_reg == value);
        stat.ins_at = !stat.le && left_stat.le;
        stat.hit    = stat.eq && !left_stat.eq;
        stat.rd_hit = below && (32'(position) == INDEX);
        ge          = below && !(stat.le && !stat.eq);

        entry_next = entry_reg;
        if (ctrl.insert_en) begin
            if (stat.ins_at) begin
                entry_next = value;
            end else if (!stat.le) begin
                entry_next = left_entry;
            end
        end else if (ctrl.delete_en && ge) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== test/tb_sorted_list_insert_delete_top.sv =====
// Testbench for sorted_list_insert_delete_top: a directed table, then random insert,
// delete and read items; each result checked against the shadow list or a known row.
// Depends on sli_pkg and the RTL of the sorted list block.
`default_nettype none

module tb_sorted_list_insert_delete_top;
    import sli_pkg::*;

    localparam int LIST_CAP    = 16;
    localparam int RAND_ITEMS  = 1425;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AT     = 400;
    localparam int IDLE_LIMIT  = 3000;
    localparam int REPORT_MAX  = 10;

    localparam logic [1:0] OP_READ_ALT = 2'd3;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    typedef struct packed {
        logic     known;
        sli_out_t res;
    } fixed_res_t;

    typedef struct packed {
        sli_in_t    item;
        fixed_res_t tag;
    } dir_row_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    sli_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    sli_out_t m_data;

    logic signed [31:0] list_vals [LIST_CAP];
    int                 list_len = 0;

    sli_out_t   result_q [$];
    fixed_res_t fixed_q [$];
    dir_row_t   dir_rows [$];

    int   err_count   = 0;
    int   idle_cycles = 0;
    int   rx_wait     = 0;
    bit   rx_burst    = 1'b0;
    bit   hold_req    = 1'b0;
    logic hold_off    = 1'b0;
    bit   tx_burst    = 1'b0;

    sorted_list_insert_delete_top #(
        .CAPACITY(LIST_CAP)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic sli_out_t list_apply(input sli_in_t it);
        sli_out_t           r;
        logic signed [31:0] v;
        int                 at;
        int                 i;
        r  = '0;
        v  = it.value;
        at = 0;
        case (it.operation)
            OP_INSERT: begin
                if (list_len >= LIST_CAP) begin
                    r.status = ST_FULL;
                end else begin
                    while (at < list_len && list_vals[at] <= v) at++;
                    for (i = list_len; i > at; i--) list_vals[i] = list_vals[i - 1];
                    list_vals[at] = v;
                    list_len++;
                    r.status = ST_INSERTED;
                    r.affected_position = at[3:0];
                end
            end
            OP_DELETE: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    while (at < list_len && list_vals[at] != v) at++;
                    if (at == list_len) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        for (i = at; i + 1 < list_len; i++) list_vals[i] = list_vals[i + 1];
                        list_len--;
                        r.status = ST_DELETED;
                        r.affected_position = at[3:0];
                    end
                end
            end
            default: begin
                r.affected_position = it.position;
                if (int'(it.position) < list_len) begin
                    r.status     = ST_READ_OK;
                    r.read_value = list_vals[it.position];
                end else begin
                    r.status = ST_RANGE;
                end
            end
        endcase
        r.entry_count = 5'(list_len);
        return r;
    endfunction

    task automatic send_item(input sli_in_t it, input fixed_res_t tag);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        fixed_q.push_back(tag);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Result checking and shadow list update, both sampled at the clock edge.
    always @(posedge aclk) begin : monitor
        sli_out_t   want;
        fixed_res_t tag;
        if (aresetn) begin
            if ((m_valid && m_ready) || (s_valid && s_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (m_valid && m_ready) begin
                if (result_q.size() == 0) begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("unexpected result: status %0d count %0d pos %0d value %0d",
                                 m_data.status, m_data.entry_count,
                                 m_data.affected_position, $signed(m_data.read_value));
                end else begin
                    want = result_q.pop_front();
                    if (m_data.status !== want.status
                            || m_data.entry_count !== want.entry_count
                            || m_data.affected_position !== want.affected_position
                            || m_data.read_value !== want.read_value) begin
                        err_count++;
                        if (err_count <= REPORT_MAX) begin
                            $write("mismatch: expected status %0d count %0d pos %0d value %0d, ",
                                   want.status, want.entry_count, want.affected_position,
                                   $signed(want.read_value));
                            $display("got status %0d count %0d pos %0d value %0d",
                                     m_data.status, m_data.entry_count,
                                     m_data.affected_position, $signed(m_data.read_value));
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = list_apply(s_data);
                tag  = fixed_q.pop_front();
                result_q.push_back(tag.known ? tag.res : want);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_off) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
                rx_wait = rx_burst ? 0 : $urandom_range(0, 15);
            end
            if (rx_wait > 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        wait (hold_req);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge aclk);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        sli_in_t            item;
        logic [1:0]         op;
        logic signed [31:0] val;
        logic signed [31:0] pool [6];
        mix_t               mix;
        int                 roll;
        int                 n;

        pool = '{32'sd0, 32'sd7, -32'sd7, 32'sd1000, -32'sd1, 32'sd42};

        // Known results are typed in only where the list state makes them obvious.
        dir_rows.push_back({OP_READ,     32'h0000_0000, 4'd0,  1'b1, ST_RANGE, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_DELETE,   32'h0000_0005, 4'd0,  1'b1, ST_EMPTY, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_READ,     32'h0000_0000, 4'd15, 1'b1, ST_RANGE, 5'd0, 4'd15, 32'h0});
        dir_rows.push_back({OP_READ_ALT, 32'hFFFF_FFFF, 4'd5,  1'b1, ST_RANGE, 5'd0, 4'd5, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'h8000_0000, 4'd0, 1'b1, ST_INSERTED, 5'd1, 4'd0, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'h7FFF_FFFF, 4'd0, 1'b1, ST_INSERTED, 5'd2, 4'd1, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'h0000_0000, 4'd0,  1'b0, 3'd0, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'hFFFF_FFFF, 4'd0,  1'b0, 3'd0, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'h0000_0000, 4'd0,  1'b0, 3'd0, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'h0000_0005, 4'd0,  1'b0, 3'd0, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'hFFFF_FFFB, 4'd0,  1'b0, 3'd0, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'h0000_0064, 4'd0,  1'b0, 3'd0, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'h4000_0000, 4'd0,  1'b0, 3'd0, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'hC000_0000, 4'd0,  1'b0, 3'd0, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'h0000_0007, 4'd0,  1'b0, 3'd0, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'h0000_0007, 4'd0,  1'b0, 3'd0, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'hFFFF_FF9C, 4'd0,  1'b0, 3'd0, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'h0000_0001, 4'd0,  1'b0, 3'd0, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'h7FFF_FFFE, 4'd0,  1'b0, 3'd0, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'h8000_0001, 4'd0,  1'b0, 3'd0, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_INSERT, 32'h0000_0003, 4'd0, 1'b1, ST_FULL, 5'd16, 4'd0, 32'h0});
        dir_rows.push_back({OP_READ,   32'h0000_0000, 4'd15, 1'b0, 3'd0, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_READ,   32'h0000_0000, 4'd0,  1'b0, 3'd0, 5'd0, 4'd0, 32'h0});
        dir_rows.push_back({OP_DELETE, 32'h0000_3039, 4'd0, 1'b1, ST_NOT_FOUND, 5'd16, 4'd0,
                            32'h0});
        dir_rows.push_back({OP_DELETE, 32'h7FFF_FFFF, 4'd0,  1'b0, 3'd0, 5'd0, 4'd0, 32'h0});

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[k]) send_item(dir_rows[k].item, dir_rows[k].tag);

        mix = MIX_EVEN;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 60 == 0) begin
                mix      = mix_t'($urandom_range(0, 2));
                tx_burst = ($urandom_range(0, 3) == 0);
            end
            if (n == HOLD_AT) begin
                hold_req = 1'b1;
                tx_burst = 1'b1;
            end
            roll = $urandom_range(0, 99);
            case (mix)
                MIX_FILL:  op = roll < 70 ? OP_INSERT : (roll < 85 ? OP_DELETE : OP_READ);
                MIX_DRAIN: op = roll < 20 ? OP_INSERT : (roll < 80 ? OP_DELETE : OP_READ);
                default: begin
                    if (roll < 40)      op = OP_INSERT;
                    else if (roll < 75) op = OP_DELETE;
                    else if (roll < 95) op = OP_READ;
                    else                op = OP_READ_ALT;
                end
            endcase
            roll = $urandom_range(0, 9);
            if (roll < 6)       val = pool[$urandom_range(0, 5)];
            else if (roll < 8)  val = $urandom;
            else if (roll == 8) val = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            else                val = $signed($urandom_range(0, 20)) - 32'sd10;
            item.operation = op;
            item.value     = val;
            item.position  = 4'($urandom_range(0, 15));
            send_item(item, '0);
        end
        s_valid <= 1'b0;

        while (result_q.size() != 0 || fixed_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_count == 0 && result_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
